>>> src/bblru_pkg.sv
package bblru_pkg;

    // Table geometry and field widths
    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int SIZE_BITS  = 24;
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam int EVC_BITS   = 5;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    localparam logic [SIZE_BITS-1:0] MAX_BYTES_RST = SIZE_BITS'(1048576);
    localparam logic [EVC_BITS-1:0]  EVC_SAT       = '1;

    // Register index of the byte budget
    localparam logic [PADDR_BITS-3:0] REG_MAX_BYTES = '0;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [SIZE_BITS-1:0] item_size;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic                 resident;
        logic [EVC_BITS-1:0]  evicted_count;
        logic [SIZE_BITS-1:0] used_bytes;
    } rsp_t;

    // Contents of one cell of the recency chain
    typedef struct packed {
        logic                 valid;
        logic [KEY_BITS-1:0]  key;
        logic [SIZE_BITS-1:0] size;
    } cell_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD,
        CELL_KILL
    } cell_op_t;

    typedef enum logic [2:0] {
        CH_NOP,
        CH_PROMOTE,
        CH_INSERT,
        CH_DROP_TAIL,
        CH_CLEAR
    } chain_op_t;

    typedef struct packed {
        chain_op_t            op;
        logic [KEY_BITS-1:0]  key;
        logic [SIZE_BITS-1:0] size;
    } chain_cmd_t;

    typedef struct packed {
        logic                 hit;
        logic [SIZE_BITS-1:0] tail_size;
    } chain_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT,
        ST_INSERT
    } state_t;

endpackage

>>> src/bblru_cell.sv
module bblru_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bblru_pkg::cell_op_t            op,
    input  bblru_pkg::cell_t               prev,
    input  bblru_pkg::cell_t               load,
    input  logic [bblru_pkg::KEY_BITS-1:0] lookup_key,
    output bblru_pkg::cell_t               cur,
    output logic                           match
);
    import bblru_pkg::*;

    logic                 valid_reg, valid_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;

    // Next contents: hold, take neighbor, take front data, or drop
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        size_next  = size_reg;
        case (op)
            CELL_HOLD:
            begin
                valid_next = valid_reg;
            end
            CELL_SHIFT:
            begin
                valid_next = prev.valid;
                key_next   = prev.key;
                size_next  = prev.size;
            end
            CELL_LOAD:
            begin
                valid_next = load.valid;
                key_next   = load.key;
                size_next  = load.size;
            end
            CELL_KILL:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        size_reg <= size_next;
    end

    assign cur   = '{valid: valid_reg, key: key_reg, size: size_reg};
    assign match = valid_reg && (key_reg == lookup_key);

endmodule

>>> src/bblru_chain.sv
module bblru_chain (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bblru_pkg::chain_cmd_t  cmd,
    output bblru_pkg::chain_stat_t stat
);
    import bblru_pkg::*;

    cell_t                cells [ENTRIES];
    cell_t                prevs [ENTRIES];
    cell_op_t             ops   [ENTRIES];
    logic [ENTRIES-1:0]   match;
    logic [ENTRIES-1:0]   upto;
    logic [ENTRIES-1:0]   tail;
    logic [SIZE_BITS-1:0] hit_size;
    logic [SIZE_BITS-1:0] tail_size;
    cell_t                load;

    // Cells at or ahead of the hit position, and the last valid cell
    always_comb
    begin
        logic acc;
        acc = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            acc     = acc | match[i];
            upto[i] = acc;
        end
    end

    always_comb
    begin
        hit_size  = '0;
        tail_size = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_size  = hit_size  | (match[i] ? cells[i].size : '0);
            tail_size = tail_size | (tail[i]  ? cells[i].size : '0);
        end
    end

    // Front data: the hit entry on a promote, the request on an insert
    assign load = '{valid: 1'b1, key: cmd.key,
                    size: (cmd.op == CH_PROMOTE) ? hit_size : cmd.size};

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign prevs[g] = '0;
            end
            else
            begin : g_body
                assign prevs[g] = cells[g-1];
            end

            if (g == ENTRIES - 1)
            begin : g_last
                assign tail[g] = cells[g].valid;
            end
            else
            begin : g_mid
                assign tail[g] = cells[g].valid && !cells[g+1].valid;
            end

            always_comb
            begin
                case (cmd.op)
                    CH_PROMOTE:
                        ops[g] = (g == 0) ? CELL_LOAD : (upto[g] ? CELL_SHIFT : CELL_HOLD);
                    CH_INSERT:
                        ops[g] = (g == 0) ? CELL_LOAD : CELL_SHIFT;
                    CH_DROP_TAIL:
                        ops[g] = tail[g] ? CELL_KILL : CELL_HOLD;
                    CH_CLEAR:
                        ops[g] = CELL_KILL;
                    default:
                        ops[g] = CELL_HOLD;
                endcase
            end

            bblru_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (ops[g]),
                .prev       (prevs[g]),
                .load       (load),
                .lookup_key (cmd.key),
                .cur        (cells[g]),
                .match      (match[g])
            );
        end
    endgenerate

    assign stat = '{hit: |match, tail_size: tail_size};

endmodule

>>> src/byte_budget_lru_cache.sv
// Size-weighted LRU cache with a byte budget and a 16-entry table.
// Request channel: present req (key, item_size) with start; the item is
// taken at the clock edge where start is high and busy is low. busy stays
// high while the item is worked on.
// Result channel: done is high for one cycle with rsp (hit, resident,
// evicted_count, used_bytes); the receiver cannot stall it, so results
// are never held back. done shows in the first cycle with busy low, and
// a new item may be started in that same cycle.
// Flow: a hit or an item larger than the budget ends in the lookup state.
// A stored miss goes on to the evict and insert states and evicts k
// entries (at most ENTRIES), one eviction per cycle from the tail of the
// recency chain.
// The chain keeps entries ordered by recency: a hit moves its entry to
// the front, an insert shifts every cell back by one.
// Configuration: APB register 0 (address 0) holds the byte budget; write
// it only while idle. Reset empties the cache and sets the budget to 1 MiB.
module byte_budget_lru_cache (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  bblru_pkg::req_t                    req,
    output logic                               done,
    output bblru_pkg::rsp_t                    rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bblru_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [bblru_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [bblru_pkg::PDATA_BITS-1:0]   prdata,
    output logic                               pready
);
    import bblru_pkg::*;

    state_t               state_reg, state_next;
    req_t                 req_reg;
    logic [SIZE_BITS-1:0] max_reg;
    logic [SIZE_BITS-1:0] used_reg, used_next;
    logic [SIZE_BITS:0]   work_reg, work_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [EVC_BITS-1:0]  evc_reg, evc_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;
    chain_cmd_t           cmd;
    chain_stat_t          stat;
    logic                 accept;
    logic                 cfg_wr;
    logic                 oversize;
    logic                 evict_now;
    logic [EVC_BITS-1:0]  evc_inc;
    logic [EVC_BITS-1:0]  count_sat;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign oversize  = req_reg.item_size > max_reg;
    assign evict_now = ((work_reg > {1'b0, max_reg}) || (int'(count_reg) == ENTRIES))
                       && (count_reg != '0);
    assign evc_inc   = (evc_reg == EVC_SAT) ? evc_reg : evc_reg + 1'b1;
    assign count_sat = (int'(count_reg) > int'(EVC_SAT)) ? EVC_SAT : EVC_BITS'(count_reg);

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_BITS-1:2] == REG_MAX_BYTES) ?
                    PDATA_BITS'(max_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_BYTES_RST;
        end
        else if (cfg_wr && (paddr[PADDR_BITS-1:2] == REG_MAX_BYTES))
        begin
            max_reg <= pwdata[SIZE_BITS-1:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (stat.hit || oversize)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                if (!evict_now)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: chain command, bookkeeping and the result
    always_comb
    begin
        cmd        = '{op: CH_NOP, key: req_reg.key, size: req_reg.item_size};
        used_next  = used_reg;
        work_next  = work_reg;
        count_next = count_reg;
        evc_next   = evc_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                evc_next = '0;
            end
            ST_LOOKUP:
            begin
                if (stat.hit)
                begin
                    cmd.op    = CH_PROMOTE;
                    done_next = 1'b1;
                    rsp_next  = '{hit: 1'b1, resident: 1'b1,
                                  evicted_count: '0, used_bytes: used_reg};
                end
                else if (oversize)
                begin
                    cmd.op     = CH_CLEAR;
                    used_next  = '0;
                    count_next = '0;
                    done_next  = 1'b1;
                    rsp_next   = '{hit: 1'b0, resident: 1'b0,
                                   evicted_count: count_sat, used_bytes: '0};
                end
                else
                begin
                    work_next = {1'b0, used_reg} + {1'b0, req_reg.item_size};
                end
            end
            ST_EVICT:
            begin
                if (evict_now)
                begin
                    cmd.op     = CH_DROP_TAIL;
                    work_next  = work_reg - {1'b0, stat.tail_size};
                    count_next = count_reg - 1'b1;
                    evc_next   = evc_inc;
                end
            end
            ST_INSERT:
            begin
                cmd.op     = CH_INSERT;
                used_next  = work_reg[SIZE_BITS-1:0];
                count_next = count_reg + 1'b1;
                done_next  = 1'b1;
                rsp_next   = '{hit: 1'b0, resident: 1'b1,
                               evicted_count: evc_reg,
                               used_bytes: work_reg[SIZE_BITS-1:0]};
            end
            default:
            begin
                cmd.op = CH_NOP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        work_reg <= work_next;
        evc_reg  <= evc_next;
        rsp_reg  <= rsp_next;
    end

    bblru_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // A hit always leaves the item cached
    a_hit_resident: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.hit) |-> rsp.resident)
        else $error("hit reported without residency");

    // Entry count never exceeds the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= ENTRIES)
        else $error("entry count beyond table depth");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("not busy after accept");

    // A result only follows a cycle of work
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(busy))
        else $error("result without preceding work");

endmodule
